[hw/rtl/pwm_prescaler_period_calc_top_assert.svh]
`ifndef PWM_PRESCALER_PERIOD_CALC_TOP_ASSERT_SVH
`define PWM_PRESCALER_PERIOD_CALC_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pwm_ppc_pkg.sv]
package pwm_ppc_pkg;

  localparam int DATA_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int CODE_W     = 3;
  localparam int PRESCALE_W = 11;
  localparam int PC_W       = 5;

  localparam logic [DATA_W-1:0] CLOCK_RESET_HZ = 32'd100000000;
  localparam logic [CODE_W-1:0] CODE_MAX       = 3'd7;
  localparam logic [CODE_W-1:0] HS_TOP_FACTOR  = 3'd7;

  localparam logic [1:0] KIND_ARM   = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_ARMED    = 2'd1;
  localparam logic [1:0] ST_NO_PRESCALER = 2'd2;
  localparam logic [1:0] ST_ZERO_FREQ    = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR_PRESCALE,
    OP_DIV_Q,
    OP_LOAD_Q,
    OP_INC_C,
    OP_INC_H,
    OP_STORE_PRESCALE,
    OP_DIV_P,
    OP_EMIT_OK,
    OP_EMIT_ZERO_FREQ,
    OP_EMIT_NO_PRESC,
    OP_EMIT_CLOSE,
    OP_EMIT_NOT_ARMED
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_KIND_NOT_ARM,
    C_KIND_NOT_SET,
    C_FREQ_ZERO,
    C_DIV_BUSY,
    C_C_FITS,
    C_C_LAST,
    C_H_FITS,
    C_NOT_ARMED
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic kind_arm;
    logic kind_set;
    logic freq_zero;
    logic div_busy;
    logic c_fits;
    logic c_last;
    logic h_fits;
    logic armed;
  } flags_t;

  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_DIV_WAIT  = 5'd4;
  localparam logic [PC_W-1:0] PC_C_TEST    = 5'd6;
  localparam logic [PC_W-1:0] PC_H_TEST    = 5'd9;
  localparam logic [PC_W-1:0] PC_H_FOUND   = 5'd11;
  localparam logic [PC_W-1:0] PC_PER_DIV   = 5'd12;
  localparam logic [PC_W-1:0] PC_PER_WAIT  = 5'd13;
  localparam logic [PC_W-1:0] PC_SET       = 5'd15;
  localparam logic [PC_W-1:0] PC_SET_WAIT  = 5'd19;
  localparam logic [PC_W-1:0] PC_ZERO_FREQ = 5'd21;
  localparam logic [PC_W-1:0] PC_NO_PRESC  = 5'd22;
  localparam logic [PC_W-1:0] PC_CLOSE     = 5'd23;
  localparam logic [PC_W-1:0] PC_NOT_ARMED = 5'd24;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      5'd0:  w = '{OP_NOP,            C_NO_START,     PC_IDLE};
      5'd1:  w = '{OP_NOP,            C_KIND_NOT_ARM, PC_SET};
      5'd2:  w = '{OP_CLR_PRESCALE,   C_FREQ_ZERO,    PC_ZERO_FREQ};
      5'd3:  w = '{OP_DIV_Q,          C_NEVER,        PC_IDLE};
      5'd4:  w = '{OP_NOP,            C_DIV_BUSY,     PC_DIV_WAIT};
      5'd5:  w = '{OP_LOAD_Q,         C_NEVER,        PC_IDLE};
      5'd6:  w = '{OP_NOP,            C_C_FITS,       PC_H_TEST};
      5'd7:  w = '{OP_NOP,            C_C_LAST,       PC_NO_PRESC};
      5'd8:  w = '{OP_INC_C,          C_ALWAYS,       PC_C_TEST};
      5'd9:  w = '{OP_NOP,            C_H_FITS,       PC_H_FOUND};
      5'd10: w = '{OP_INC_H,          C_ALWAYS,       PC_H_TEST};
      5'd11: w = '{OP_STORE_PRESCALE, C_NEVER,        PC_IDLE};
      5'd12: w = '{OP_DIV_P,          C_NEVER,        PC_IDLE};
      5'd13: w = '{OP_NOP,            C_DIV_BUSY,     PC_PER_WAIT};
      5'd14: w = '{OP_EMIT_OK,        C_ALWAYS,       PC_IDLE};
      5'd15: w = '{OP_NOP,            C_KIND_NOT_SET, PC_CLOSE};
      5'd16: w = '{OP_NOP,            C_NOT_ARMED,    PC_NOT_ARMED};
      5'd17: w = '{OP_NOP,            C_FREQ_ZERO,    PC_ZERO_FREQ};
      5'd18: w = '{OP_DIV_Q,          C_NEVER,        PC_IDLE};
      5'd19: w = '{OP_NOP,            C_DIV_BUSY,     PC_SET_WAIT};
      5'd20: w = '{OP_LOAD_Q,         C_ALWAYS,       PC_PER_DIV};
      5'd21: w = '{OP_EMIT_ZERO_FREQ, C_ALWAYS,       PC_IDLE};
      5'd22: w = '{OP_EMIT_NO_PRESC,  C_ALWAYS,       PC_IDLE};
      5'd23: w = '{OP_EMIT_CLOSE,     C_ALWAYS,       PC_IDLE};
      5'd24: w = '{OP_EMIT_NOT_ARMED, C_ALWAYS,       PC_IDLE};
      default: w = '{OP_NOP,          C_ALWAYS,       PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PRESCALE_W-1:0] pair_prescale(input logic [CODE_W-1:0] c,
                                                          input logic [CODE_W-1:0] h);
    logic [PRESCALE_W-1:0] base;
    base = (h == '0) ? PRESCALE_W'(1) : {{(PRESCALE_W-CODE_W-1){1'b0}}, h, 1'b0};
    return base << c;
  endfunction

  // p >= q / 0xFFFF holds exactly when q < (p + 1) * 0xFFFF
  function automatic logic [DATA_W:0] fit_limit(input logic [PRESCALE_W-1:0] p);
    logic [DATA_W:0] pp;
    pp = {{(DATA_W+1-PRESCALE_W){1'b0}}, p} + (DATA_W+1)'(1);
    return (pp << PERIOD_W) - pp;
  endfunction

endpackage

[hw/rtl/pwm_ppc_div.sv]
module pwm_ppc_div
  import pwm_ppc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem, quot[DATA_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DATA_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quot <= {quot[DATA_W-2:0], ge};
    end
  end

  assign quotient = quot;

endmodule

[hw/rtl/pwm_ppc_seq.sv]
module pwm_ppc_seq
  import pwm_ppc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output op_t    op,
  output logic   busy
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_t           word;
  logic            take;

  always_comb begin
    word = rom_word(pc);
    case (word.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_START:     take = !flags.start;
      C_KIND_NOT_ARM: take = !flags.kind_arm;
      C_KIND_NOT_SET: take = !flags.kind_set;
      C_FREQ_ZERO:    take = flags.freq_zero;
      C_DIV_BUSY:     take = flags.div_busy;
      C_C_FITS:       take = flags.c_fits;
      C_C_LAST:       take = flags.c_last;
      C_H_FITS:       take = flags.h_fits;
      C_NOT_ARMED:    take = !flags.armed;
      default:        take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign op   = word.op;
  assign busy = pc != PC_IDLE;

endmodule

[hw/rtl/pwm_prescaler_period_calc_top.sv]
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// request  | start, busy        | kind, freq_hz
// result   | done (one cycle)   | period_count, clock_div_code, hs_clock_div_code,
//          |                    | status, period_overflow
// config   | cfg_wr_en          | cfg_wr_data (input clock in hertz)
//
// One request at a time; busy stays high from acceptance until the result cycle.
// A successful arm keeps busy high through two divider runs plus a prescaler search,
// which is longest for the largest prescale. Set also uses two divider runs; an arm
// with no prescaler uses one divider run and the search over all clock codes, and close and other errors use neither.
// The divider is a shared bit-serial unit, and the control program runs one step per cycle.
// rst clears the kept prescale and loads the default input clock of 100 MHz.
// Results are never held off; done marks each for exactly one cycle.
module pwm_prescaler_period_calc_top
  import pwm_ppc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [DATA_W-1:0]   freq_hz,
  input  logic                cfg_wr_en,
  input  logic [DATA_W-1:0]   cfg_wr_data,
  output logic                done,
  output logic [PERIOD_W-1:0] period_count,
  output logic [CODE_W-1:0]   clock_div_code,
  output logic [CODE_W-1:0]   hs_clock_div_code,
  output logic [1:0]          status,
  output logic                period_overflow
);

  logic [DATA_W-1:0]     clock_hz;
  logic [1:0]            req_kind;
  logic [DATA_W-1:0]     req_freq;
  logic [DATA_W-1:0]     q_val;
  logic [CODE_W-1:0]     c_code;
  logic [CODE_W-1:0]     h_code;
  logic [PRESCALE_W-1:0] prescale;

  op_t                   op;
  flags_t                flags;
  logic                  div_start;
  logic                  div_busy;
  logic [DATA_W-1:0]     div_a;
  logic [DATA_W-1:0]     div_b;
  logic [DATA_W-1:0]     div_quot;
  logic [PRESCALE_W-1:0] pair_p;
  logic [PRESCALE_W-1:0] c_top_p;
  logic                  accept;

  assign accept = start && !busy;

  always_comb begin
    pair_p  = pair_prescale(c_code, h_code);
    c_top_p = pair_prescale(c_code, HS_TOP_FACTOR);

    flags.start     = start;
    flags.kind_arm  = req_kind == KIND_ARM;
    flags.kind_set  = req_kind == KIND_SET;
    flags.freq_zero = req_freq == '0;
    flags.div_busy  = div_busy;
    flags.c_fits    = {1'b0, q_val} < fit_limit(c_top_p);
    flags.c_last    = c_code == CODE_MAX;
    flags.h_fits    = {1'b0, q_val} < fit_limit(pair_p);
    flags.armed     = prescale != '0;

    div_start = (op == OP_DIV_Q) || (op == OP_DIV_P);
    div_a     = (op == OP_DIV_P) ? q_val : clock_hz;
    div_b     = (op == OP_DIV_P) ? {{(DATA_W-PRESCALE_W){1'b0}}, prescale} : req_freq;
  end

  pwm_ppc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  pwm_ppc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET_HZ;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_freq <= freq_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
    end else begin
      case (op)
        OP_CLR_PRESCALE:   prescale <= '0;
        OP_STORE_PRESCALE: prescale <= pair_p;
        OP_EMIT_CLOSE: begin
          if (req_kind == KIND_CLOSE) begin
            prescale <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD_Q: begin
        q_val  <= div_quot;
        c_code <= '0;
        h_code <= '0;
      end
      OP_INC_C: c_code <= c_code + CODE_W'(1);
      OP_INC_H: h_code <= h_code + CODE_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == OP_EMIT_OK) || (op == OP_EMIT_ZERO_FREQ) || (op == OP_EMIT_NO_PRESC)
              || (op == OP_EMIT_CLOSE) || (op == OP_EMIT_NOT_ARMED);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_EMIT_OK: begin
        period_count      <= div_quot[PERIOD_W-1:0];
        clock_div_code    <= c_code;
        hs_clock_div_code <= h_code;
        status            <= ST_OK;
        period_overflow   <= |div_quot[DATA_W-1:PERIOD_W];
      end
      OP_EMIT_ZERO_FREQ, OP_EMIT_NO_PRESC, OP_EMIT_CLOSE, OP_EMIT_NOT_ARMED: begin
        period_count      <= '0;
        clock_div_code    <= '0;
        hs_clock_div_code <= '0;
        period_overflow   <= 1'b0;
        case (op)
          OP_EMIT_ZERO_FREQ: status <= ST_ZERO_FREQ;
          OP_EMIT_NO_PRESC:  status <= ST_NO_PRESCALER;
          OP_EMIT_NOT_ARMED: status <= ST_NOT_ARMED;
          default:           status <= ST_OK;
        endcase
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/pwm_ppc_checker.sv]
`include "pwm_prescaler_period_calc_top_assert.svh"

module pwm_ppc_checker
  import pwm_ppc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [PERIOD_W-1:0] period_count,
  input logic [CODE_W-1:0]   clock_div_code,
  input logic [CODE_W-1:0]   hs_clock_div_code,
  input logic [1:0]          status,
  input logic                period_overflow
);

  `PPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

  `PPC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")

  `PPC_ASSERT_NOW(a_busy_ends_done, !$past(rst) && $fell(busy), done,
                  "busy dropped with no result")

  `PPC_ASSERT_NOW(a_error_zero, done && (status != ST_OK),
                  (period_count == '0) && (clock_div_code == '0) &&
                  (hs_clock_div_code == '0) && !period_overflow,
                  "error result with nonzero fields")

endmodule

bind pwm_prescaler_period_calc_top pwm_ppc_checker u_checker (.*);
